@@ rtl/psr_pkg.sv @@
// Shared constants, codes and types of the packed symmetric rank-1 update block.
`default_nettype none

package psr_pkg;

    localparam int MAX_ORDER    = 64;
    localparam int PACKED_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int DATA_W       = 64;
    localparam int ORDER_W      = $clog2(MAX_ORDER + 1);
    localparam int MAT_AW       = $clog2(PACKED_DEPTH);
    localparam int VEC_AW       = $clog2(MAX_ORDER);

    // configuration register indexes
    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_LOWER = 2'd1;
    localparam logic [1:0] CFG_SIZE  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_WR_MAT = 2'd0,
        CMD_WR_VEC = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_RD_MAT = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAT_RD,
        ST_COL_RD,
        ST_COL_CHK,
        ST_T_WAIT,
        ST_ENT_RD,
        ST_ENT_MUL,
        ST_ENT_WAIT
    } state_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        logic  sat;
        word_t product;
    } mul_rsp_t;

endpackage

`default_nettype wire

@@ rtl/packed_symmetric_rank1_update.sv @@
// Packed symmetric rank-1 update (A := alpha*x*x^T + A), Q31.32, packed upper or lower storage.
//
// One transaction in, one result out. Matrix and x writes answer at once (result is
// registered the edge the transaction is taken); a matrix read answers through the
// matrix RAM's registered read and the ST_MAT_RD state. An update walks the packed
// columns serially against both RAMs and one shared multi-cycle multiplier: a column
// whose x element is zero is skipped, any other column first forms alpha*x[j], then each
// of its packed entries is read, multiplied, added with saturation and written back.
// No transaction is taken while an update runs. Matrix and x entries must be written before
// they are read. Configuration may only be written while the block is idle; an order above
// 64 acts as 64.
`default_nettype none

module packed_symmetric_rank1_update (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [1:0]         command,
    input  wire logic [11:0]        element_index,
    input  wire logic signed [63:0] data_value,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [63:0] read_value,
    output      logic               saturated,
    output      logic               index_error,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);

    // configuration
    psr_pkg::word_t alpha_reg;
    logic           lower_reg;
    logic [6:0]     size_reg;

    // control state
    psr_pkg::state_t state_reg, state_next;
    logic            sat_reg, sat_next;
    logic [5:0]      col_reg, col_next;
    logic [5:0]      row_reg, row_next;
    logic [11:0]     k_reg, k_next;
    logic [6:0]      n_walk_reg, n_walk_next;
    logic            lower_walk_reg, lower_walk_next;
    psr_pkg::word_t  t_reg, t_next;
    psr_pkg::word_t  word_reg, word_next;

    // result register
    logic           out_valid_reg;
    psr_pkg::word_t read_value_reg;
    logic           saturated_reg;
    logic           index_error_reg;
    logic           out_load;
    psr_pkg::word_t out_value;
    logic           out_err;

    // RAM ports
    logic           mat_we, mat_re;
    logic [11:0]    mat_waddr, mat_raddr;
    psr_pkg::word_t mat_wdata;
    logic [63:0]    mat_rdata;
    logic           vec_we, vec_re;
    logic [5:0]     vec_waddr, vec_raddr;
    psr_pkg::word_t vec_wdata;
    logic [63:0]    vec_rdata;

    psr_pkg::mul_req_t mul_req;
    psr_pkg::mul_rsp_t mul_rsp;

    psr_pkg::cmd_t cmd;
    logic [6:0]    n_cur;
    logic [13:0]   tri_prod;
    logic [11:0]   pcount;
    logic          mat_oob, vec_oob;
    logic          in_ready_c;

    logic [5:0]     n_last;
    logic           last_col, last_row;
    logic [6:0]     col_len;
    psr_pkg::word_t sum_raw, sum_sat;
    logic           add_ovf;

    assign cmd      = psr_pkg::cmd_t'(command);
    assign n_cur    = (size_reg > 7'(psr_pkg::MAX_ORDER)) ? 7'(psr_pkg::MAX_ORDER) : size_reg;
    assign tri_prod = {7'd0, n_cur} * {7'd0, n_cur + 7'd1};
    assign pcount   = tri_prod[12:1];
    assign mat_oob  = element_index >= pcount;
    assign vec_oob  = element_index >= {5'd0, n_cur};

    assign n_last   = 6'(n_walk_reg - 7'd1);
    assign last_col = col_reg == n_last;
    assign last_row = lower_walk_reg ? (row_reg == n_last) : (row_reg == col_reg);
    assign col_len  = lower_walk_reg ? (n_walk_reg - {1'b0, col_reg})
                                     : ({1'b0, col_reg} + 7'd1);

    // saturating accumulate of the product into the stored word
    assign sum_raw = word_reg + mul_rsp.product;
    assign add_ovf = (word_reg[63] == mul_rsp.product[63]) && (sum_raw[63] != word_reg[63]);
    assign sum_sat = add_ovf ? {word_reg[63], {63{~word_reg[63]}}} : sum_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            lower_reg <= 1'b0;
            size_reg  <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psr_pkg::CFG_ALPHA: alpha_reg <= cfg_data;
                psr_pkg::CFG_LOWER: lower_reg <= cfg_data[0];
                psr_pkg::CFG_SIZE:  size_reg  <= cfg_data[6:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sat_next        = sat_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        k_next          = k_reg;
        n_walk_next     = n_walk_reg;
        lower_walk_next = lower_walk_reg;
        t_next          = t_reg;
        word_next       = word_reg;
        in_ready_c      = 1'b0;
        mat_we          = 1'b0;
        mat_waddr       = k_reg;
        mat_wdata       = sum_sat;
        mat_re          = 1'b0;
        mat_raddr       = k_reg;
        vec_we          = 1'b0;
        vec_waddr       = element_index[5:0];
        vec_wdata       = data_value;
        vec_re          = 1'b0;
        vec_raddr       = row_reg;
        mul_req.start   = 1'b0;
        mul_req.a       = vec_rdata;
        mul_req.b       = t_reg;
        out_load        = 1'b0;
        out_value       = '0;
        out_err         = 1'b0;

        unique case (state_reg)
            psr_pkg::ST_IDLE:
            begin
                in_ready_c = !out_valid_reg || out_ready;
                if (in_valid && in_ready_c)
                begin
                    unique case (cmd)
                        psr_pkg::CMD_WR_MAT:
                        begin
                            out_load = 1'b1;
                            if (mat_oob)
                            begin
                                out_err = 1'b1;
                            end
                            else
                            begin
                                mat_we    = 1'b1;
                                mat_waddr = element_index;
                                mat_wdata = data_value;
                                sat_next  = 1'b0;
                            end
                        end
                        psr_pkg::CMD_WR_VEC:
                        begin
                            out_load = 1'b1;
                            if (vec_oob)
                            begin
                                out_err = 1'b1;
                            end
                            else
                            begin
                                vec_we = 1'b1;
                            end
                        end
                        psr_pkg::CMD_UPDATE:
                        begin
                            if (n_cur == 7'd0 || alpha_reg == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                n_walk_next     = n_cur;
                                lower_walk_next = lower_reg;
                                col_next        = 6'd0;
                                k_next          = 12'd0;
                                state_next      = psr_pkg::ST_COL_RD;
                            end
                        end
                        psr_pkg::CMD_RD_MAT:
                        begin
                            if (mat_oob)
                            begin
                                out_load = 1'b1;
                                out_err  = 1'b1;
                            end
                            else
                            begin
                                mat_re     = 1'b1;
                                mat_raddr  = element_index;
                                state_next = psr_pkg::ST_MAT_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            psr_pkg::ST_MAT_RD:
            begin
                out_load   = 1'b1;
                out_value  = mat_rdata;
                state_next = psr_pkg::ST_IDLE;
            end
            psr_pkg::ST_COL_RD:
            begin
                vec_re     = 1'b1;
                vec_raddr  = col_reg;
                state_next = psr_pkg::ST_COL_CHK;
            end
            psr_pkg::ST_COL_CHK:
            begin
                if (vec_rdata == 64'd0)
                begin
                    // column skipped: step over its packed entries
                    k_next = k_reg + {5'd0, col_len};
                    if (last_col)
                    begin
                        out_load   = 1'b1;
                        state_next = psr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 6'd1;
                        state_next = psr_pkg::ST_COL_RD;
                    end
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = alpha_reg;
                    mul_req.b     = vec_rdata;
                    row_next      = lower_walk_reg ? col_reg : 6'd0;
                    state_next    = psr_pkg::ST_T_WAIT;
                end
            end
            psr_pkg::ST_T_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    t_next     = mul_rsp.product;
                    sat_next   = sat_reg | mul_rsp.sat;
                    state_next = psr_pkg::ST_ENT_RD;
                end
            end
            psr_pkg::ST_ENT_RD:
            begin
                vec_re     = 1'b1;
                vec_raddr  = row_reg;
                mat_re     = 1'b1;
                mat_raddr  = k_reg;
                state_next = psr_pkg::ST_ENT_MUL;
            end
            psr_pkg::ST_ENT_MUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = vec_rdata;
                mul_req.b     = t_reg;
                word_next     = mat_rdata;
                state_next    = psr_pkg::ST_ENT_WAIT;
            end
            psr_pkg::ST_ENT_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    mat_we   = 1'b1;
                    sat_next = sat_reg | mul_rsp.sat | add_ovf;
                    k_next   = k_reg + 12'd1;
                    if (last_row)
                    begin
                        if (last_col)
                        begin
                            out_load   = 1'b1;
                            state_next = psr_pkg::ST_IDLE;
                        end
                        else
                        begin
                            col_next   = col_reg + 6'd1;
                            state_next = psr_pkg::ST_COL_RD;
                        end
                    end
                    else
                    begin
                        row_next   = row_reg + 6'd1;
                        state_next = psr_pkg::ST_ENT_RD;
                    end
                end
            end
            default:
            begin
                state_next = psr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psr_pkg::ST_IDLE;
            sat_reg        <= 1'b0;
            col_reg        <= 6'd0;
            row_reg        <= 6'd0;
            k_reg          <= 12'd0;
            n_walk_reg     <= 7'd0;
            lower_walk_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sat_reg        <= sat_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            k_reg          <= k_next;
            n_walk_reg     <= n_walk_next;
            lower_walk_reg <= lower_walk_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        word_reg <= word_next;
        if (out_load)
        begin
            read_value_reg  <= out_value;
            saturated_reg   <= sat_next;
            index_error_reg <= out_err;
        end
    end

    psr_ram #(
        .WIDTH (psr_pkg::DATA_W),
        .DEPTH (psr_pkg::PACKED_DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    psr_ram #(
        .WIDTH (psr_pkg::DATA_W),
        .DEPTH (psr_pkg::MAX_ORDER)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .re    (vec_re),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    psr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign in_ready    = in_ready_c;
    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign saturated   = saturated_reg;
    assign index_error = index_error_reg;

    // a result is only loaded when the output register is free or draining
    ap_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transaction completed");

    ap_wr_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == psr_pkg::CMD_WR_MAT && !mat_oob) |=> !sat_reg)
        else $error("matrix write did not clear the saturation flag");

    ap_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psr_pkg::ST_ENT_RD) |-> (k_reg < 12'(psr_pkg::PACKED_DEPTH)))
        else $error("packed index ran past the matrix store");

endmodule

`default_nettype wire

@@ rtl/psr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module psr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/psr_mul.sv @@
// Multi-cycle signed Q31.32 multiplier: four 32x32 partial products, truncation, saturation.
`default_nettype none

module psr_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire psr_pkg::mul_req_t req,
    output      psr_pkg::mul_rsp_t rsp
);

    localparam logic [2:0] STEP_PP_LAST = 3'd3;
    localparam logic [2:0] STEP_LAST    = 3'd5;

    logic         busy_reg, busy_next;
    logic [2:0]   step_reg, step_next;
    logic         done_reg, done_next;

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] pp_reg;
    logic [127:0] acc_reg;
    logic         sat_reg;
    logic [63:0]  res_reg;

    logic [63:0]  ma_c, mb_c;
    logic [31:0]  op_x, op_y;
    logic [63:0]  pp_c;
    logic [127:0] pp_pos;
    logic [63:0]  mag_c, limit_c, mag_sat;
    logic         ovf_c;

    // magnitudes of the operands; the most negative value maps to 2^63
    assign ma_c = req.a[63] ? (~req.a + 64'd1) : req.a;
    assign mb_c = req.b[63] ? (~req.b + 64'd1) : req.b;

    always_comb
    begin
        unique case (step_reg)
            3'd0:
            begin
                op_x = ma_reg[31:0];
                op_y = mb_reg[31:0];
            end
            3'd1:
            begin
                op_x = ma_reg[31:0];
                op_y = mb_reg[63:32];
            end
            3'd2:
            begin
                op_x = ma_reg[63:32];
                op_y = mb_reg[31:0];
            end
            default:
            begin
                op_x = ma_reg[63:32];
                op_y = mb_reg[63:32];
            end
        endcase
        pp_c = {32'd0, op_x} * {32'd0, op_y};
        unique case (step_reg)
            3'd0:    pp_pos = {64'd0, pp_c};
            3'd1,
            3'd2:    pp_pos = {32'd0, pp_c, 32'd0};
            default: pp_pos = {pp_c, 64'd0};
        endcase
    end

    assign mag_c   = acc_reg[95:32];
    assign limit_c = {neg_reg, {63{~neg_reg}}};
    assign ovf_c   = (|acc_reg[127:96]) || (mag_c > limit_c);
    assign mag_sat = ovf_c ? limit_c : mag_c;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= ma_c;
            mb_reg  <= mb_c;
            neg_reg <= req.a[63] ^ req.b[63];
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg <= STEP_PP_LAST)
            begin
                pp_reg <= pp_pos;
            end
            // the partial product registered in the previous step is added to the accumulator in this one
            if (step_reg != 3'd0 && step_reg != STEP_LAST)
            begin
                acc_reg <= acc_reg + pp_reg;
            end
            if (step_reg == STEP_LAST)
            begin
                sat_reg <= ovf_c;
                res_reg <= neg_reg ? (~mag_sat + 64'd1) : mag_sat;
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.sat     = sat_reg;
    assign rsp.product = res_reg;

endmodule

`default_nettype wire
